[hw/rtl/msf_pkg.sv]
// Shared types and constants of the scalarizing fitness block.
`default_nettype none

package msf_pkg;

	localparam int unsigned OBJ_W   = 32;                 // Q16.16 objective and ideal
	localparam int unsigned WGT_W   = 25;                 // Q1.24 weight, 2^24 is 1.0
	localparam int unsigned FIT_W   = 64;                 // Q32.32 fitness
	localparam int unsigned PROD_W  = OBJ_W + 1 + WGT_W + 1;
	localparam int unsigned QUO_W   = FIT_W - 1;          // quotient bits that can be set
	localparam int unsigned DIV_STEPS = QUO_W;
	localparam int unsigned DCNT_W  = $clog2(DIV_STEPS + 1);
	localparam int unsigned SAT_SHIFT = 23;               // d >= w * 2^23 overflows
	localparam int unsigned TERM_SHIFT = 8;               // Q16.16 x Q1.24 to Q32.32

	localparam logic [FIT_W-1:0] MAXPOS = {1'b0, {(FIT_W-1){1'b1}}};

	typedef enum logic [1:0] {
		MODE_WSUM = 2'd0,
		MODE_TCH  = 2'd1,
		MODE_INV  = 2'd2
	} msf_mode_t;

	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = WGT_W;

	localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_EPS   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FLOOR = 2'd2;

	localparam logic [WGT_W-1:0] EPS_RESET   = 25'd17;
	localparam logic [WGT_W-1:0] FLOOR_RESET = 25'd17;

	typedef struct packed {
		logic signed [OBJ_W-1:0] objective_value;
		logic        [WGT_W-1:0] weight;
		logic signed [OBJ_W-1:0] ideal_value;
		logic                    last_element;
	} msf_in_t;

	typedef struct packed {
		logic signed [FIT_W-1:0] fitness;
		logic                    saturated;
	} msf_out_t;

	typedef struct packed {
		logic load;      // capture an input transaction
		logic calc;      // difference, effective weight, divider set-up
		logic mul;       // one product
		logic div_step;  // one quotient bit
		logic acc;       // fold the term into the running value
		logic finish;    // hand the result to the output register
	} msf_cmd_t;

	typedef struct packed {
		msf_mode_t mode;
		logic      div_sat;
		logic      div_done;
		logic      close;
		logic      out_free;
	} msf_sts_t;

endpackage

`default_nettype wire

[hw/rtl/msf_ctrl.sv]
// Controller state machine of the scalarizing fitness block.
`default_nettype none

module msf_ctrl
	import msf_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_stall,
	input  wire msf_sts_t sts,
	output msf_cmd_t      cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CALC,
		ST_MUL,
		ST_DIV,
		ST_ACC,
		ST_FINISH
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_CALC;
				end
				ST_CALC: begin
					case (sts.mode)
						MODE_WSUM, MODE_TCH: state_q <= ST_MUL;
						MODE_INV:            state_q <= ST_DIV;
						default:             state_q <= ST_ACC;
					endcase
				end
				ST_MUL: state_q <= ST_ACC;
				ST_DIV: begin
					if (sts.div_sat || sts.div_done) state_q <= ST_ACC;
				end
				ST_ACC: state_q <= sts.close ? ST_FINISH : ST_IDLE;
				ST_FINISH: begin
					if (sts.out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		cmd          = '0;
		cmd.load     = (state_q == ST_IDLE) && in_valid;
		cmd.calc     = (state_q == ST_CALC);
		cmd.mul      = (state_q == ST_MUL);
		cmd.div_step = (state_q == ST_DIV) && !sts.div_sat && !sts.div_done;
		cmd.acc      = (state_q == ST_ACC);
		cmd.finish   = (state_q == ST_FINISH);
	end

endmodule

`default_nettype wire

[hw/rtl/msf_datapath.sv]
// Datapath: configuration, operand registers, multiplier, divider, accumulator, output.
`default_nettype none

module msf_datapath
	import msf_pkg::*;
#(
	parameter int unsigned MAX_OBJECTIVES = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire msf_in_t               in_data,
	input  wire msf_cmd_t              cmd,
	output msf_sts_t                   sts,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output msf_out_t                   out_data
);

	localparam int unsigned CNT_W = $clog2(MAX_OBJECTIVES + 1);

	// configuration
	msf_mode_t        mode_cfg_q;
	logic [WGT_W-1:0] eps_q;
	logic [WGT_W-1:0] floor_q;

	// captured item
	logic signed [OBJ_W-1:0] obj_q;
	logic signed [OBJ_W-1:0] ideal_q;
	logic [WGT_W-1:0]        w_q;
	msf_mode_t               mode_q;
	logic                    close_q;

	// per-item working values
	logic [OBJ_W-1:0]         diff_q;
	logic [WGT_W-1:0]         weff_q;
	logic signed [PROD_W-1:0] prod_q;
	logic                     div_sat_q;
	logic [WGT_W-1:0]         rem_q;
	logic [QUO_W-1:0]         dq_q;
	logic [DCNT_W-1:0]        div_cnt_q;

	// solution state
	logic [FIT_W-1:0] running_q;
	logic             ovf_q;
	logic [CNT_W-1:0] cnt_q;

	// output register
	logic     out_valid_q;
	msf_out_t out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_cfg_q <= MODE_TCH;
			eps_q      <= EPS_RESET;
			floor_q    <= FLOOR_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_MODE:  mode_cfg_q <= msf_mode_t'(cfg_data[1:0]);
				CFG_EPS:   eps_q      <= cfg_data;
				CFG_FLOOR: floor_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			obj_q   <= in_data.objective_value;
			ideal_q <= in_data.ideal_value;
			w_q     <= in_data.weight;
			mode_q  <= mode_cfg_q;
			close_q <= in_data.last_element || (cnt_q == CNT_W'(MAX_OBJECTIVES - 1));
		end
	end

	// difference and effective weight
	logic signed [OBJ_W:0] sd;
	logic [OBJ_W:0]        sd_neg;
	logic [OBJ_W-1:0]      diff;
	logic [WGT_W-1:0]      weff;

	always_comb begin
		sd     = {obj_q[OBJ_W-1], obj_q} - {ideal_q[OBJ_W-1], ideal_q};
		sd_neg = -sd;
		diff   = sd[OBJ_W] ? sd_neg[OBJ_W-1:0] : sd[OBJ_W-1:0];
		weff   = (w_q < eps_q) ? floor_q : w_q;
	end

	// multiplier operands: signed objective times weight, or distance times weight
	logic signed [OBJ_W:0] mul_a;
	logic signed [WGT_W:0] mul_b;

	always_comb begin
		if (mode_q == MODE_WSUM) begin
			mul_a = {obj_q[OBJ_W-1], obj_q};
			mul_b = {1'b0, w_q};
		end else begin
			mul_a = {1'b0, diff_q};
			mul_b = {1'b0, weff_q};
		end
	end

	// one restoring division step
	logic [WGT_W:0] r2;
	logic [WGT_W:0] r2_sub;
	logic           q_bit;

	always_comb begin
		r2     = {rem_q, dq_q[QUO_W-1]};
		r2_sub = r2 - {1'b0, weff_q};
		q_bit  = (r2 >= {1'b0, weff_q});
	end

	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			diff_q    <= diff;
			weff_q    <= weff;
			div_sat_q <= (weff == '0) ||
				({{(WGT_W + SAT_SHIFT - OBJ_W){1'b0}}, diff} >= {weff, {SAT_SHIFT{1'b0}}});
			rem_q     <= {{(WGT_W - (OBJ_W - SAT_SHIFT)){1'b0}}, diff[OBJ_W-1:SAT_SHIFT]};
			dq_q      <= {diff[SAT_SHIFT-1:0], {(QUO_W - SAT_SHIFT){1'b0}}};
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			rem_q     <= q_bit ? r2_sub[WGT_W-1:0] : r2[WGT_W-1:0];
			dq_q      <= {dq_q[QUO_W-2:0], q_bit};
			div_cnt_q <= div_cnt_q + 1'b1;
		end
		if (cmd.mul) begin
			prod_q <= mul_a * mul_b;
		end
	end

	// term and accumulation
	logic signed [FIT_W-1:0] prod_ext;
	logic [FIT_W-1:0]        term_mul;
	logic [FIT_W-1:0]        term_div;
	logic [FIT_W-1:0]        sum;
	logic                    sum_ovf;
	logic [FIT_W-1:0]        run_next;
	logic                    ovf_next;

	always_comb begin
		prod_ext = {{(FIT_W - PROD_W){prod_q[PROD_W-1]}}, prod_q};
		term_mul = prod_ext >>> TERM_SHIFT;
		term_div = div_sat_q ? MAXPOS : {1'b0, dq_q};
		sum      = running_q + term_mul;
		sum_ovf  = (running_q[FIT_W-1] == term_mul[FIT_W-1]) &&
			(sum[FIT_W-1] != running_q[FIT_W-1]);
		run_next = running_q;
		ovf_next = ovf_q;
		case (mode_q)
			MODE_WSUM: begin
				if (sum_ovf) begin
					run_next = running_q[FIT_W-1] ? {1'b1, {(FIT_W-1){1'b0}}} : MAXPOS;
					ovf_next = 1'b1;
				end else begin
					run_next = sum;
				end
			end
			MODE_TCH: begin
				if (term_mul > running_q) run_next = term_mul;
			end
			MODE_INV: begin
				if (term_div > running_q) run_next = term_div;
				if (div_sat_q) ovf_next = 1'b1;
			end
			default: ;
		endcase
	end

	logic out_free;
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= '0;
			ovf_q     <= 1'b0;
			cnt_q     <= '0;
		end else if (cmd.acc) begin
			running_q <= run_next;
			ovf_q     <= ovf_next;
			if (!close_q) cnt_q <= cnt_q + 1'b1;
		end else if (cmd.finish && out_free) begin
			running_q <= '0;
			ovf_q     <= 1'b0;
			cnt_q     <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish && out_free) begin
			out_q.fitness   <= running_q;
			out_q.saturated <= ovf_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		sts          = '0;
		sts.mode     = mode_q;
		sts.div_sat  = div_sat_q;
		sts.div_done = (div_cnt_q == DCNT_W'(DIV_STEPS));
		sts.close    = close_q;
		sts.out_free = out_free;
	end

	a_clear_after_finish: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish && out_free |=> running_q == '0 && !ovf_q && cnt_q == '0)
		else $error("solution state not cleared after result hand-over");

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |=> rem_q < weff_q)
		else $error("division remainder not below divisor");

	a_tch_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.acc && mode_q == MODE_TCH && !ovf_q |=> !ovf_q)
		else $error("Tchebycheff term raised the saturation flag");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q < CNT_W'(MAX_OBJECTIVES))
		else $error("objective count beyond limit");

endmodule

`default_nettype wire

[hw/rtl/moead_scalarizing_fitness.sv]
// Top level of the MOEA/D scalarizing fitness block.
// Usage:
//  - Input channel (in_valid / in_stall / in_data): one transaction per objective of a
//    solution: objective, weight and ideal value, last_element on the final one. The
//    solution also closes on its MAX_OBJECTIVES-th objective.
//  - Output channel (out_valid / out_stall / out_data): one transaction per closed
//    solution: Q32.32 fitness and a saturation flag.
//  - Configuration: write mode, eps_threshold and floor_weight with cfg_wr_en while idle.
//  - Per objective in weighted sum and Tchebycheff: capture, difference, multiply,
//    accumulate. Inverted Tchebycheff replaces the multiply with the radix-2 divider
//    that yields one of 63 quotient bits per cycle, plus a step to see it finish. A
//    saturating division skips the iterations; the unused mode code skips multiply
//    and divider. Closing a solution adds a step to move the result into the output
//    register once it frees; the result is visible the cycle after.
//  - The result register separates the sides: new objectives are taken while a
//    result waits. If the receiver stalls and a further solution closes, the block
//    holds that result and stalls its input until the register frees.
//  - Reset clears the running value, flag, objective count and output valid, and
//    loads mode Tchebycheff with eps_threshold and floor_weight at 17.
`default_nettype none

module moead_scalarizing_fitness
	import msf_pkg::*;
#(
	parameter int unsigned MAX_OBJECTIVES = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire msf_in_t               in_data,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output msf_out_t                   out_data,
	input  wire logic                  cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	msf_cmd_t cmd;
	msf_sts_t sts;

	// sequence one objective at a time
	msf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// arithmetic, solution state and result register
	msf_datapath #(
		.MAX_OBJECTIVES (MAX_OBJECTIVES)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
// Self-checking testbench of the MOEA/D scalarizing fitness block.
`timescale 1ns / 1ps

module tb_top
	import msf_pkg::*;
();

	localparam int unsigned SOL_MAX  = 16;          // objectives that force a solution closed
	localparam int unsigned ONE_Q24  = 1 << 24;     // weight of 1.0
	localparam int unsigned SETTLE   = 100;         // cycles past the slowest objective
	localparam int unsigned DRAIN_MAX = 20000;      // bound on waiting for outstanding results
	localparam logic [1:0]  MODE_UNUSED = 2'd3;     // register code with no operation behind it

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	msf_in_t               in_data = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	msf_out_t              out_data;
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// predictor state: register copies and the solution being folded
	logic [1:0]       cfg_mode  = MODE_TCH;
	logic [WGT_W-1:0] cfg_eps   = EPS_RESET;
	logic [WGT_W-1:0] cfg_floor = FLOOR_RESET;
	logic [FIT_W-1:0] acc_value = '0;
	logic             acc_sat = 1'b0;
	int unsigned      obj_count = 0;

	msf_in_t  obj_q[$];        // objectives waiting for the driver
	msf_out_t fitness_q[$];    // fitness results still owed by the block

	int unsigned objs_queued = 0;
	int unsigned objs_taken = 0;
	int unsigned n_checked = 0;
	int unsigned n_sat = 0;
	int unsigned n_settings = 0;
	int unsigned errors = 0;

	int unsigned burst_left = 1;
	int unsigned gap_left = 0;
	int unsigned rx_left = 0;

	logic in_fire;
	assign in_fire = in_valid && !in_stall;

	moead_scalarizing_fitness #(
		.MAX_OBJECTIVES(SOL_MAX)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Fold one accepted objective into the running value; close the solution on the
	// last_element flag or once SOL_MAX objectives have arrived.
	task automatic fold_objective(input msf_in_t it);
		logic signed [63:0] obj64, ideal64, sd, prod;
		logic [63:0] diff, weff, term, sum;
		logic [71:0] num;
		msf_out_t res;
		obj64 = {{32{it.objective_value[31]}}, it.objective_value};
		ideal64 = {{32{it.ideal_value[31]}}, it.ideal_value};
		sd = obj64 - ideal64;
		diff = (sd < 0) ? -sd : sd;
		// tiny weights fall back to the floor weight (Tchebycheff modes only)
		weff = (it.weight < cfg_eps) ? 64'(cfg_floor) : 64'(it.weight);
		case (cfg_mode)
		MODE_WSUM: begin
			prod = obj64 * $signed({39'd0, it.weight});
			term = prod >>> TERM_SHIFT;
			sum = acc_value + term;
			if (acc_value[63] == term[63] && sum[63] != acc_value[63]) begin
				acc_sat = 1'b1;
				sum = term[63] ? {1'b1, {63{1'b0}}} : MAXPOS;
			end
			acc_value = sum;
		end
		MODE_TCH: begin
			term = (diff * weff) >> TERM_SHIFT;
			if (term > acc_value)
				acc_value = term;
		end
		MODE_INV: begin
			// a zero divisor or a quotient beyond 63 bits clips to the largest value
			if (weff == 0 || diff >= (weff << SAT_SHIFT)) begin
				acc_sat = 1'b1;
				term = MAXPOS;
			end else begin
				num = {diff[31:0], 40'd0};
				term = 64'(num / weff);
			end
			if (term > acc_value)
				acc_value = term;
		end
		default: ;  // the unused mode code leaves the running value alone
		endcase
		obj_count++;
		if (it.last_element || obj_count >= SOL_MAX) begin
			res.fitness = acc_value;
			res.saturated = acc_sat;
			fitness_q.push_back(res);
			acc_value = '0;
			acc_sat = 1'b0;
			obj_count = 0;
		end
	endtask

	task automatic check_fitness(input msf_out_t got);
		msf_out_t want;
		if (fitness_q.size() == 0) begin
			$error("unexpected result: fitness %0d, saturated %0d", got.fitness, got.saturated);
			errors++;
		end else begin
			want = fitness_q.pop_front();
			n_checked++;
			if (got.saturated)
				n_sat++;
			if (got.fitness !== want.fitness) begin
				$error("fitness: expected %0d, got %0d", want.fitness, got.fitness);
				errors++;
			end
			if (got.saturated !== want.saturated) begin
				$error("saturated: expected %0d, got %0d", want.saturated, got.saturated);
				errors++;
			end
		end
	endtask

	function automatic int unsigned pick_burst();
		// now and then a long burst gives a stretch without gaps
		return ($urandom_range(0, 4) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 8);
	endfunction

	// Driver: hold the payload while stalled, advance on acceptance, idle between bursts.
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_fire) begin
				fold_objective(in_data);
				objs_taken++;
			end
			if (!in_valid || in_fire) begin
				if (gap_left != 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (obj_q.size() == 0) begin
					in_valid <= 1'b0;
				end else begin
					in_data <= obj_q.pop_front();
					in_valid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left = pick_burst();
						gap_left = $urandom_range(0, 10);
					end else begin
						burst_left--;
					end
				end
			end
		end
	end

	// Monitor: check each accepted result and stall on runs of random length.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				check_fitness(out_data);
			if (rx_left != 0) begin
				rx_left--;
			end else if (out_stall) begin
				out_stall <= 1'b0;
				rx_left = ($urandom_range(0, 3) == 0) ? $urandom_range(200, 400) :
					$urandom_range(0, 12);
			end else begin
				out_stall <= 1'b1;
				rx_left = ($urandom_range(0, 5) == 0) ? $urandom_range(5, 20) :
					$urandom_range(0, 3);
			end
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
		CFG_MODE:  cfg_mode = val[1:0];
		CFG_EPS:   cfg_eps = val;
		CFG_FLOOR: cfg_floor = val;
		default: ;
		endcase
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic set_regs(input logic [1:0] m, input logic [WGT_W-1:0] e,
			input logic [WGT_W-1:0] f);
		write_reg(CFG_MODE, CFG_DATA_W'(m));
		write_reg(CFG_EPS, e);
		write_reg(CFG_FLOOR, f);
		n_settings++;
	endtask

	task automatic queue_objective(input logic [31:0] obj, input logic [WGT_W-1:0] w,
			input logic [31:0] ideal, input logic last);
		msf_in_t it;
		it.objective_value = obj;
		it.weight = w;
		it.ideal_value = ideal;
		it.last_element = last;
		obj_q.push_back(it);
		objs_queued++;
	endtask

	// Wait until every objective is taken and every result has come back or DRAIN_MAX
	// runs out, then let a trailing objective that closes nothing run through the divider.
	task automatic wait_quiet();
		int unsigned n;
		n = 0;
		while (objs_taken != objs_queued)
			@(posedge clk);
		while (fitness_q.size() != 0 && n < DRAIN_MAX) begin
			@(posedge clk);
			n++;
		end
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_q16();
		logic [31:0] r;
		r = $urandom;
		case ($urandom_range(0, 5))
		0: return 32'h7FFF_FFFF;
		1: return 32'h8000_0000;
		2: return {{12{r[19]}}, r[19:0]};
		default: return r;
		endcase
	endfunction

	function automatic logic [WGT_W-1:0] rand_weight();
		case ($urandom_range(0, 7))
		0: return '0;
		1: return WGT_W'($urandom_range(1, 40));    // around the eps reset value
		2: return WGT_W'(ONE_Q24);
		3: return WGT_W'($urandom);                   // above one as well
		default: return WGT_W'($urandom_range(0, ONE_Q24));
		endcase
	endfunction

	// Queue about n objectives: mostly well-formed solutions, some overlong runs with
	// stray last flags that rely on the objective limit to close.
	task automatic queue_solutions(input int unsigned n);
		int unsigned left, len, k;
		logic [31:0] obj, ideal, r;
		left = n;
		while (left > 0) begin
			if ($urandom_range(0, 99) < 85)
				len = $urandom_range(1, SOL_MAX);
			else
				len = $urandom_range(SOL_MAX + 1, 30);
			for (k = 0; k < len; k++) begin
				obj = rand_q16();
				r = $urandom;
				ideal = ($urandom_range(0, 2) == 0) ? obj + {{16{r[15]}}, r[15:0]} : rand_q16();
				queue_objective(obj, rand_weight(), ideal,
					(len <= SOL_MAX) ? (k == len - 1) : ($urandom_range(0, 7) == 0));
			end
			left = (len >= left) ? 0 : left - len;
		end
	endtask

	initial begin
		int unsigned ph, r;
		logic [1:0] m;
		logic [WGT_W-1:0] e, f;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: Tchebycheff, eps and floor at 17
		queue_objective(32'h7FFF_FFFF, WGT_W'(ONE_Q24), 32'h8000_0000, 1'b1);
		queue_objective(32'h8000_0000, 25'd5, 32'h7FFF_FFFF, 1'b0);   // weight under eps
		queue_objective(32'h0000_0000, 25'd0, 32'h0000_0000, 1'b1);
		wait_quiet();

		// weighted sum: largest weights above one, both signs, flooring of -1
		write_reg(CFG_MODE, CFG_DATA_W'(MODE_WSUM));
		queue_objective(32'h7FFF_FFFF, 25'h1FF_FFFF, 32'h0000_0000, 1'b0);
		queue_objective(32'h7FFF_FFFF, 25'h1FF_FFFF, 32'h0000_0000, 1'b0);
		queue_objective(32'h8000_0000, 25'h1FF_FFFF, 32'h1234_5678, 1'b1);
		queue_objective(32'h8000_0000, WGT_W'(ONE_Q24), 32'h0000_0000, 1'b1);
		queue_objective(32'hFFFF_FFFF, 25'd1, 32'h0000_0000, 1'b1);
		wait_quiet();

		// inverted Tchebycheff with eps 0: zero divisor, tiny weight, clipped quotient
		set_regs(MODE_INV, '0, 25'd1);
		queue_objective(32'h7FFF_FFFF, WGT_W'(ONE_Q24), 32'h8000_0000, 1'b1);
		queue_objective(32'h0000_0005, 25'd0, 32'h0000_0005, 1'b1);
		queue_objective(32'h0000_0064, 25'd1, 32'h0000_0000, 1'b0);
		queue_objective(32'h7FFF_FFFF, 25'd1, 32'h0000_0000, 1'b1);
		wait_quiet();

		// Tchebycheff with eps and floor at one
		set_regs(MODE_TCH, WGT_W'(ONE_Q24), WGT_W'(ONE_Q24));
		queue_objective(32'h7FFF_FFFF, 25'd3, 32'h8000_0000, 1'b1);
		queue_objective(32'h0000_1234, WGT_W'(ONE_Q24), 32'h0000_0000, 1'b1);
		wait_quiet();

		// unused mode code: nothing accumulates
		write_reg(CFG_MODE, CFG_DATA_W'(MODE_UNUSED));
		queue_objective(32'h7FFF_FFFF, WGT_W'(ONE_Q24), 32'h0000_0000, 1'b0);
		queue_objective(32'h8000_0000, 25'h1FF_FFFF, 32'h7FFF_FFFF, 1'b1);
		wait_quiet();

		// mode switched inside an open solution
		write_reg(CFG_MODE, CFG_DATA_W'(MODE_TCH));
		queue_objective(32'h03E8_0000, WGT_W'(ONE_Q24), 32'h0000_0000, 1'b0);
		wait_quiet();
		write_reg(CFG_MODE, CFG_DATA_W'(MODE_WSUM));
		queue_objective(32'hFFFB_0000, 25'h080_0000, 32'h0000_0000, 1'b1);
		wait_quiet();

		// random phases; a phase may stop inside a solution, so settings also change
		// part way through one
		for (ph = 0; ph < 12; ph++) begin
			case (ph)
			0: set_regs(MODE_WSUM, '0, 25'd1);
			1: set_regs(MODE_TCH, WGT_W'(ONE_Q24), WGT_W'(ONE_Q24));
			2: set_regs(MODE_INV, WGT_W'(ONE_Q24), 25'd1);
			3: set_regs(MODE_INV, '0, WGT_W'(ONE_Q24));
			default: begin
				r = $urandom_range(0, 9);
				m = (r < 3) ? MODE_WSUM : (r < 6) ? MODE_TCH : (r < 9) ? MODE_INV : MODE_UNUSED;
				case ($urandom_range(0, 3))
				0: e = '0;
				1: e = WGT_W'(ONE_Q24);
				2: e = EPS_RESET;
				default: e = WGT_W'($urandom_range(0, ONE_Q24));
				endcase
				case ($urandom_range(0, 3))
				0: f = 25'd1;
				1: f = WGT_W'(ONE_Q24);
				2: f = FLOOR_RESET;
				default: f = WGT_W'($urandom_range(1, ONE_Q24));
				endcase
				set_regs(m, e, f);
			end
			endcase
			queue_solutions(128);
			wait_quiet();
		end

		if (fitness_q.size() != 0) begin
			$error("%0d fitness results never arrived", fitness_q.size());
			errors++;
		end
		$display("Covered %0d objectives under %0d register settings in all modes;",
			objs_taken, n_settings);
		$display("%0d fitness results checked, %0d of them saturated.", n_checked, n_sat);
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// watchdog: well beyond the slowest correct run
	initial begin
		#3_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule
